/* hdl/rope_pkg.sv */
`timescale 1ns / 1ps

package rope_pkg;

	// rotary span and its half; fixed by the 7-bit element index
	localparam int ROTARY_WIDTH = 128;
	localparam int HALF         = ROTARY_WIDTH / 2;
	localparam int IDX_W        = $clog2(HALF);
	localparam int ENTRY_W      = 32;            // {cos, sin}, each Q1.14
	localparam int VAL_W        = 30;            // Q30 working values
	localparam int TERM_W       = 3;

	localparam logic [63:0] THETA_BASE = 64'd10000;
	localparam logic [63:0] FREQ_BASE  = 64'd683565276;
	localparam logic [31:0] HALFPI_Q30 = 32'd1686629713;
	localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

	// Horner divisors 72, 42, 20, 6 (sine) then 56, 30, 12, 2 (cosine), as
	// reciprocals: floor(n / d) = (n * m) >> s, m = ceil(2^s / d),
	// s = 30 + ceil(log2 d); exact for any n below 2^30
	typedef logic [7:0][31:0] recip_tab_t;
	localparam recip_tab_t RECIP_TAB = {
		32'd1073741824, 32'd1431655766, 32'd1145324613, 32'd1227133514,
		32'd1431655766, 32'd1717986919, 32'd1636178018, 32'd1908874354
	};
	typedef logic [7:0][5:0] shift_tab_t;
	localparam shift_tab_t SHIFT_TAB = {
		6'd31, 6'd34, 6'd35, 6'd36, 6'd33, 6'd35, 6'd36, 6'd37
	};
	localparam logic [TERM_W-1:0] SIN_LAST = 3'd3;
	localparam logic [TERM_W-1:0] COS_LAST = 3'd7;

	typedef logic [HALF-1:0][31:0] freq_tab_t;

	// inverse frequencies in turns per position, Q0.32
	function automatic freq_tab_t build_freq();
		logic [63:0] r;
		logic [63:0] cand;
		logic [63:0] p;
		logic [63:0] pw;
		freq_tab_t   tab;
		r = 64'd0;
		for (int b = 31; b >= 0; b--) begin
			cand = r | (64'd1 << b);
			p = 64'd1 << 32;
			for (int n = 0; n < HALF; n++) begin
				if (p != 64'd0) begin
					p = (p * cand) >> 32;
				end
			end
			if (p * THETA_BASE <= (64'd1 << 32)) begin
				r = cand;
			end
		end
		pw = 64'd1 << 32;
		for (int k = 0; k < HALF; k++) begin
			tab[k] = 32'((FREQ_BASE * pw + (64'd1 << 31)) >> 32);
			pw = (pw * r) >> 32;
		end
		return tab;
	endfunction

	localparam freq_tab_t FREQ_TAB = build_freq();

	typedef enum logic [3:0] {
		FS_IDLE,
		FS_PH_MUL,
		FS_PH_FOLD,
		FS_X_MUL,
		FS_X_TAKE,
		FS_X2_MUL,
		FS_X2_TAKE,
		FS_T_MUL,
		FS_T_LOAD,
		FS_T_DIV,
		FS_T_SUB,
		FS_S_MUL,
		FS_S_TAKE,
		FS_WRITE
	} fill_state_t;

	typedef struct packed {
		logic               we;
		logic [IDX_W-1:0]   addr;
		logic [ENTRY_W-1:0] data;
	} fill_wr_t;

endpackage

/* hdl/rotary_position_embedding.sv */
`timescale 1ns / 1ps
// Items pass store read, products, round and saturate; one item per cycle unless
// out_ready is low or a refill runs. A token_position write starts a refill of the
// 64-entry cos/sin store, paced by the shared multiplier, four steps per Horner
// term with a reciprocal multiply for each division; in_ready is low for its duration.
// Reset: pipeline empty, token_position 0; the cos/sin store is undefined until written.

module rotary_position_embedding (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [5:0]         head_index,
	input  logic               key_not_query,
	input  logic [6:0]         elem_index,
	input  logic signed [15:0] first_value,
	input  logic signed [15:0] second_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [5:0]         head_tag,
	output logic               key_tag,
	output logic [6:0]         elem_tag,
	output logic signed [15:0] first_out,
	output logic signed [15:0] second_out
);

	// fill engine -> store write port
	rope_pkg::fill_wr_t fill_wr;
	logic               fill_busy;

	// rotation pipe -> store read port
	logic                         ram_re;
	logic [rope_pkg::IDX_W-1:0]   ram_raddr;
	logic [rope_pkg::ENTRY_W-1:0] ram_rdata;

	// Position write: phase = position * freq mod one turn, folded to an
	// eighth turn, Taylor sin/cos, stored as {cos, sin} in Q1.14.
	rope_fill u_fill (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.busy      (fill_busy),
		.wr        (fill_wr)
	);

	// cos/sin store, one entry per pair
	rope_ram #(
		.WIDTH (rope_pkg::ENTRY_W),
		.DEPTH (rope_pkg::HALF)
	) u_store (
		.clk   (clk),
		.we    (fill_wr.we),
		.waddr (fill_wr.addr),
		.wdata (fill_wr.data),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Streaming rotation: a*c - b*s, b*c + a*s, rounded half up and saturated;
	// pairs at or beyond HALF pass straight through.
	rope_rot u_rot (
		.clk           (clk),
		.arst_n        (arst_n),
		.fill_busy     (fill_busy),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.head_index    (head_index),
		.key_not_query (key_not_query),
		.elem_index    (elem_index),
		.first_value   (first_value),
		.second_value  (second_value),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.head_tag      (head_tag),
		.key_tag       (key_tag),
		.elem_tag      (elem_tag),
		.first_out     (first_out),
		.second_out    (second_out)
	);

endmodule

/* hdl/rope_ram.sv */
`timescale 1ns / 1ps

module rope_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/rope_fill.sv */
`timescale 1ns / 1ps

// Refills the cos/sin store after a position write: one entry at a time
// through a shared 32x32 multiplier; each Horner division is a multiply by
// a constant reciprocal and a shift.
module rope_fill (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	output logic              busy,
	output rope_pkg::fill_wr_t wr
);

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;

	rope_pkg::fill_state_t state_q, state_d;

	logic [15:0]                  pos_q;
	logic [rope_pkg::IDX_W-1:0]   k_q;
	logic [rope_pkg::TERM_W-1:0]  term_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_q;
	logic [1:0]  quad_q;
	logic        swap_q;
	logic [rope_pkg::VAL_W-1:0] v_q, x_q, x2_q, sn_q, dvd_q;
	logic [30:0] t_q;

	logic [31:0] phase;
	logic [29:0] u;
	logic [63:0] quot_full;
	logic [30:0] a_raw, b_raw;
	logic signed [15:0] s0, c0, sin_w, cos_w;

	function automatic logic signed [15:0] to_q14(input logic [30:0] v);
		logic [31:0] s;
		s = {1'b0, v} + 32'd32768;
		return s[31:16];
	endfunction

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rope_pkg::FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and outputs
	always_comb begin
		state_d = state_q;
		case (state_q)
			rope_pkg::FS_IDLE:    state_d = rope_pkg::FS_IDLE;
			rope_pkg::FS_PH_MUL:  state_d = rope_pkg::FS_PH_FOLD;
			rope_pkg::FS_PH_FOLD: state_d = rope_pkg::FS_X_MUL;
			rope_pkg::FS_X_MUL:   state_d = rope_pkg::FS_X_TAKE;
			rope_pkg::FS_X_TAKE:  state_d = rope_pkg::FS_X2_MUL;
			rope_pkg::FS_X2_MUL:  state_d = rope_pkg::FS_X2_TAKE;
			rope_pkg::FS_X2_TAKE: state_d = rope_pkg::FS_T_MUL;
			rope_pkg::FS_T_MUL:   state_d = rope_pkg::FS_T_LOAD;
			rope_pkg::FS_T_LOAD:  state_d = rope_pkg::FS_T_DIV;
			rope_pkg::FS_T_DIV:   state_d = rope_pkg::FS_T_SUB;
			rope_pkg::FS_T_SUB: begin
				if (term_q == rope_pkg::SIN_LAST) begin
					state_d = rope_pkg::FS_S_MUL;
				end else if (term_q == rope_pkg::COS_LAST) begin
					state_d = rope_pkg::FS_WRITE;
				end else begin
					state_d = rope_pkg::FS_T_MUL;
				end
			end
			rope_pkg::FS_S_MUL:   state_d = rope_pkg::FS_S_TAKE;
			rope_pkg::FS_S_TAKE:  state_d = rope_pkg::FS_T_MUL;
			rope_pkg::FS_WRITE: begin
				if (k_q == rope_pkg::IDX_W'(rope_pkg::HALF - 1)) begin
					state_d = rope_pkg::FS_IDLE;
				end else begin
					state_d = rope_pkg::FS_PH_MUL;
				end
			end
			default:              state_d = rope_pkg::FS_IDLE;
		endcase
		if (cfg_we) begin
			state_d = rope_pkg::FS_PH_MUL;
		end
		busy    = (state_q != rope_pkg::FS_IDLE);
		wr.we   = (state_q == rope_pkg::FS_WRITE);
		wr.addr = k_q;
		wr.data = {cos_w, sin_w};
	end

	// multiplier operands
	always_comb begin
		mul_a = {2'b00, x_q};
		mul_b = {1'b0, t_q};
		case (state_q)
			rope_pkg::FS_PH_MUL: begin
				mul_a = {16'd0, pos_q};
				mul_b = rope_pkg::FREQ_TAB[k_q];
			end
			rope_pkg::FS_X_MUL: begin
				mul_a = {2'b00, v_q};
				mul_b = rope_pkg::HALFPI_Q30;
			end
			rope_pkg::FS_X2_MUL: begin
				mul_a = {2'b00, x_q};
				mul_b = {2'b00, x_q};
			end
			rope_pkg::FS_T_MUL: begin
				mul_a = {2'b00, x2_q};
				mul_b = {1'b0, t_q};
			end
			rope_pkg::FS_T_DIV: begin
				mul_a = {2'b00, dvd_q};
				mul_b = rope_pkg::RECIP_TAB[term_q];
			end
			default: begin
				mul_a = {2'b00, x_q};
				mul_b = {1'b0, t_q};
			end
		endcase
	end

	assign phase     = prod_q[31:0];
	assign u         = phase[29:0];
	assign quot_full = prod_q >> rope_pkg::SHIFT_TAB[term_q];

	// control counters and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			k_q    <= '0;
			term_q <= '0;
		end else begin
			if (cfg_we) begin
				pos_q <= cfg_wdata;
				k_q   <= '0;
			end else if (state_q == rope_pkg::FS_WRITE) begin
				k_q <= k_q + 1'b1;
			end
			if (state_q == rope_pkg::FS_X2_TAKE) begin
				term_q <= '0;
			end else if (state_q == rope_pkg::FS_T_SUB) begin
				term_q <= term_q + 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			rope_pkg::FS_PH_FOLD: begin
				quad_q <= phase[31:30];
				if (u <= 30'h2000_0000) begin
					v_q    <= u;
					swap_q <= 1'b0;
				end else begin
					v_q    <= 30'(31'h4000_0000 - {1'b0, u});
					swap_q <= 1'b1;
				end
			end
			rope_pkg::FS_X_TAKE:  x_q <= prod_q[59:30];
			rope_pkg::FS_X2_TAKE: begin
				x2_q <= prod_q[59:30];
				t_q  <= rope_pkg::ONE_Q30;
			end
			rope_pkg::FS_T_LOAD:  dvd_q <= prod_q[59:30];
			rope_pkg::FS_T_SUB:   t_q <= rope_pkg::ONE_Q30 - {1'b0, quot_full[29:0]};
			rope_pkg::FS_S_TAKE: begin
				sn_q <= prod_q[59:30];
				t_q  <= rope_pkg::ONE_Q30;
			end
			default: begin
			end
		endcase
	end

	// fold back from the eighth turn, then place in the quadrant
	assign a_raw = swap_q ? t_q : {1'b0, sn_q};
	assign b_raw = swap_q ? {1'b0, sn_q} : t_q;
	assign s0    = to_q14(a_raw);
	assign c0    = to_q14(b_raw);

	always_comb begin
		case (quad_q)
			QUAD_0: begin
				sin_w = s0;
				cos_w = c0;
			end
			QUAD_1: begin
				sin_w = c0;
				cos_w = -s0;
			end
			QUAD_2: begin
				sin_w = -s0;
				cos_w = -c0;
			end
			default: begin
				sin_w = -c0;
				cos_w = s0;
			end
		endcase
	end

	a_cfg_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> busy)
		else $error("fill not started by position write");

	a_fill_ends_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(state_q == rope_pkg::FS_WRITE
			&& k_q == rope_pkg::IDX_W'(rope_pkg::HALF - 1)))
		else $error("fill ended before last entry");

	a_write_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> busy)
		else $error("store written outside a fill");

endmodule

/* hdl/rope_rot.sv */
`timescale 1ns / 1ps

// Three-stage rotation pipe: store read, four products, round and saturate.
module rope_rot (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fill_busy,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [5:0]                   head_index,
	input  logic                         key_not_query,
	input  logic [6:0]                   elem_index,
	input  logic signed [15:0]           first_value,
	input  logic signed [15:0]           second_value,
	output logic                         ram_re,
	output logic [rope_pkg::IDX_W-1:0]   ram_raddr,
	input  logic [rope_pkg::ENTRY_W-1:0] ram_rdata,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [5:0]                   head_tag,
	output logic                         key_tag,
	output logic [6:0]                   elem_tag,
	output logic signed [15:0]           first_out,
	output logic signed [15:0]           second_out
);

	logic en1, en2, en3, accept;
	logic v_s1, v_s2, v_s3;

	logic [5:0]         head_s1, head_s2;
	logic               key_s1, key_s2;
	logic [6:0]         elem_s1, elem_s2;
	logic               rot_s1, rot_s2;
	logic signed [15:0] a_s1, b_s1, a_s2, b_s2;
	logic signed [31:0] ac_s2, bs_s2, bc_s2, as_s2;
	logic signed [15:0] cos_w, sin_w;
	logic signed [32:0] diff, sum;

	function automatic logic signed [15:0] round_sat(input logic signed [32:0] x);
		logic signed [33:0] y;
		logic signed [19:0] r;
		y = {x[32], x} + 34'sd8192;
		r = y[33:14];
		if (r > 20'sd32767) begin
			return 16'sh7FFF;
		end else if (r < -20'sd32768) begin
			return 16'sh8000;
		end
		return r[15:0];
	endfunction

	// each stage moves when the one after it is empty or moving
	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1 && !fill_busy;
	assign accept   = in_valid && in_ready;

	assign ram_re    = accept;
	assign ram_raddr = elem_index[rope_pkg::IDX_W-1:0];

	assign cos_w = ram_rdata[31:16];
	assign sin_w = ram_rdata[15:0];

	assign diff = {ac_s2[31], ac_s2} - {bs_s2[31], bs_s2};
	assign sum  = {bc_s2[31], bc_s2} + {as_s2[31], as_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= accept;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_s1 <= head_index;
			key_s1  <= key_not_query;
			elem_s1 <= elem_index;
			a_s1    <= first_value;
			b_s1    <= second_value;
			rot_s1  <= (elem_index < 7'(rope_pkg::HALF));
		end
		if (en2 && v_s1) begin
			head_s2 <= head_s1;
			key_s2  <= key_s1;
			elem_s2 <= elem_s1;
			rot_s2  <= rot_s1;
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			ac_s2   <= a_s1 * cos_w;
			bs_s2   <= b_s1 * sin_w;
			bc_s2   <= b_s1 * cos_w;
			as_s2   <= a_s1 * sin_w;
		end
		if (en3 && v_s2) begin
			head_tag   <= head_s2;
			key_tag    <= key_s2;
			elem_tag   <= elem_s2;
			first_out  <= rot_s2 ? round_sat(diff) : a_s2;
			second_out <= rot_s2 ? round_sat(sum) : b_s2;
		end
	end

	assign out_valid = v_s3;

	a_no_read_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> !fill_busy)
		else $error("store read during fill");

	a_s2_moves_on: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && en3) |=> v_s3)
		else $error("item lost between product and output stage");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !en2) |=> (v_s1 && $stable(a_s1) && $stable(elem_s1)))
		else $error("stalled first stage changed");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

// Rotary position embedding bench: directed items first, then random items in
// four handshake phases. Expected pairs come from a behavioural model of the
// cos/sin refill and the rotate-half arithmetic held below.
module testbench;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int FLUSH_CYCLES = 12;      // pipeline is 3 deep; a few spare

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [15:0]        cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic [5:0]         head_index;
	logic               key_not_query;
	logic [6:0]         elem_index;
	logic signed [15:0] first_value;
	logic signed [15:0] second_value;
	logic               out_valid;
	logic               out_ready;
	logic [5:0]         head_tag;
	logic               key_tag;
	logic [6:0]         elem_tag;
	logic signed [15:0] first_out;
	logic signed [15:0] second_out;

	typedef struct {
		logic [5:0]         head;
		logic               key;
		logic [6:0]         elem;
		logic signed [15:0] first;
		logic signed [15:0] second;
	} pair_t;

	pair_t       rotated_q[$];
	logic [31:0] turn_rate[rope_pkg::HALF];
	int          cos_q14[rope_pkg::HALF];
	int          sin_q14[rope_pkg::HALF];
	int          errors;
	int          items_sent;
	int          results_seen;
	int          positions_set;
	int          cycles;
	int          send_idle_pct;     // chance in 100 of a gap before an item
	int          recv_stall_pct;    // chance in 100 of out_ready low

	rotary_position_embedding DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .head_index(head_index),
		.key_not_query(key_not_query), .elem_index(elem_index),
		.first_value(first_value), .second_value(second_value),
		.out_valid(out_valid), .out_ready(out_ready), .head_tag(head_tag),
		.key_tag(key_tag), .elem_tag(elem_tag), .first_out(first_out),
		.second_out(second_out)
	);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	// ---------------------------------------------------------------
	// behavioural model
	// ---------------------------------------------------------------

	// inverse frequency table: largest ratio r with theta * r^HALF <= 1,
	// then f0 * r^k with truncated Q0.32 products
	function automatic void make_turn_rate();
		logic [63:0] ratio, trial, acc, pw;
		ratio = 64'd0;
		for (int b = 31; b >= 0; b--) begin
			trial = ratio | (64'd1 << b);
			acc = 64'd1 << 32;
			for (int n = 0; n < rope_pkg::HALF; n++)
				if (acc != 64'd0)
					acc = (acc * trial) >> 32;
			if (acc * 64'd10000 <= (64'd1 << 32))
				ratio = trial;
		end
		pw = 64'd1 << 32;
		for (int k = 0; k < rope_pkg::HALF; k++) begin
			turn_rate[k] = 32'((64'd683565276 * pw + (64'd1 << 31)) >> 32);
			pw = (pw * ratio) >> 32;
		end
	endfunction

	// sin and cos in Q30 of an angle up to an eighth turn (v: Q30 of a quarter)
	function automatic void octant_trig(input logic [63:0] v, output logic [63:0] sv,
			output logic [63:0] cv);
		logic [63:0] one, x, x2, t;
		one = 64'd1 << 30;
		x  = (v * 64'd1686629713) >> 30;
		x2 = (x * x) >> 30;
		t = one - x2 / 72;
		t = one - ((x2 * t) >> 30) / 42;
		t = one - ((x2 * t) >> 30) / 20;
		t = one - ((x2 * t) >> 30) / 6;
		sv = (x * t) >> 30;
		t = one - x2 / 56;
		t = one - ((x2 * t) >> 30) / 30;
		t = one - ((x2 * t) >> 30) / 12;
		t = one - ((x2 * t) >> 30) / 2;
		cv = t;
	endfunction

	function automatic void refill_trig(input logic [15:0] pos);
		logic [31:0] ph;
		logic [63:0] u, a, b;
		int          s0, c0;
		for (int k = 0; k < rope_pkg::HALF; k++) begin
			ph = 32'(64'(pos) * 64'(turn_rate[k]));
			u = 64'(ph[29:0]);
			if (u <= 64'h2000_0000)
				octant_trig(u, a, b);
			else
				octant_trig(64'h4000_0000 - u, b, a);
			s0 = int'((a + 64'd32768) >> 16);
			c0 = int'((b + 64'd32768) >> 16);
			case (ph[31:30])
				2'd0: begin sin_q14[k] = s0;  cos_q14[k] = c0;  end
				2'd1: begin sin_q14[k] = c0;  cos_q14[k] = -s0; end
				2'd2: begin sin_q14[k] = -s0; cos_q14[k] = -c0; end
				default: begin sin_q14[k] = -c0; cos_q14[k] = s0; end
			endcase
		end
	endfunction

	// Q.22 to Q8.8, round half up, saturate
	function automatic logic signed [15:0] round_q8_8(input longint acc);
		longint r;
		r = (acc + 64'sd8192) >>> 14;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return 16'(r);
	endfunction

	function automatic pair_t rotate_pair(input pair_t x);
		pair_t  y;
		longint a, b, c, s;
		y = x;
		if (x.elem < rope_pkg::HALF) begin
			a = x.first;
			b = x.second;
			c = cos_q14[x.elem];
			s = sin_q14[x.elem];
			y.first  = round_q8_8(a * c - b * s);
			y.second = round_q8_8(b * c + a * s);
		end
		return y;
	endfunction

	// ---------------------------------------------------------------
	// result checker
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		pair_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (rotated_q.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected: head %0d elem %0d %0d %0d",
					$time, head_tag, elem_tag, first_out, second_out);
			end else begin
				want = rotated_q.pop_front();
				if (head_tag !== want.head || key_tag !== want.key ||
						elem_tag !== want.elem || first_out !== want.first ||
						second_out !== want.second) begin
					errors++;
					$display("%0t: mismatch expected h%0d k%0d e%0d %0d %0d",
						$time, want.head, want.key, want.elem, want.first, want.second);
					$display("%0t:          actual   h%0d k%0d e%0d %0d %0d",
						$time, head_tag, key_tag, elem_tag, first_out, second_out);
				end
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				rotated_q.size());
			$display("testbench NOT OK");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// shared tasks
	// ---------------------------------------------------------------

	// one item; valid stays up afterwards unless the next call opens a gap
	task automatic send_pair(input logic [5:0] h, input logic k, input logic [6:0] e,
			input logic signed [15:0] a, input logic signed [15:0] b);
		pair_t x;
		int    gap;
		x = '{head: h, key: k, elem: e, first: a, second: b};
		if ($urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		head_index    <= h;
		key_not_query <= k;
		elem_index    <= e;
		first_value   <= a;
		second_value  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		rotated_q.push_back(rotate_pair(x));
		items_sent++;
	endtask

	// lower valid and wait until every expected item has come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (rotated_q.size() != 0)
			@(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);
	endtask

	// new token position; only while idle. The refill holds in_ready low,
	// send_pair simply waits it out.
	task automatic set_position(input logic [15:0] pos);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= pos;
		@(posedge clk);
		cfg_we <= 1'b0;
		refill_trig(pos);
		positions_set++;
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_value();
		case ($urandom_range(7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'($urandom_range(255));
			default: return 16'($urandom);
		endcase
	endfunction

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// position 0: identity rotation, field extremes, pass-through boundary
	task automatic test_identity();
		set_position(16'd0);
		send_pair(6'd0, 1'b0, 7'd0, 16'sh7FFF, 16'sh8000);
		send_pair(6'd63, 1'b1, 7'd63, 16'sh8000, 16'sh7FFF);
		send_pair(6'd42, 1'b0, 7'd64, 16'sh1234, -16'sh0567);
		send_pair(6'd21, 1'b1, 7'd127, 16'sh8000, 16'sh8000);
		send_pair(6'd1, 1'b0, 7'd1, 16'sh0000, 16'sh0001);
	endtask

	// largest position; full-scale inputs push the sums into saturation
	task automatic test_saturation();
		set_position(16'hFFFF);
		for (int e = 0; e < 8; e++) begin
			send_pair(6'(e * 9), e[0], 7'(e * 9), 16'sh7FFF, 16'sh7FFF);
			send_pair(6'(e * 7), ~e[0], 7'(e * 9), 16'sh8000, 16'sh7FFF);
		end
		send_pair(6'd63, 1'b1, 7'd100, 16'sh7FFF, 16'sh8000);
	endtask

	// position 1: every fourth element slot once, in order
	task automatic test_all_slots();
		set_position(16'd1);
		for (int e = 0; e < rope_pkg::HALF; e += 4)
			send_pair(6'($urandom), 1'($urandom), 7'(e), rand_value(), rand_value());
	endtask

	// random items in the four handshake phases, new position per block
	task automatic test_random();
		int          phase_send[4] = '{0, 68, 0, 34};
		int          phase_recv[4] = '{0, 0, 68, 34};
		logic [15:0] pos;
		logic [6:0]  e;
		for (int ph = 0; ph < 4; ph++) begin
			for (int blk = 0; blk < 2; blk++) begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
				case ($urandom_range(3))
					0: pos = 16'hFFFF;
					1: pos = 16'($urandom_range(63));
					default: pos = 16'($urandom);
				endcase
				set_position(pos);
				send_idle_pct  = phase_send[ph];
				recv_stall_pct = phase_recv[ph];
				for (int n = 0; n < 125; n++) begin
					// mostly rotated slots, the rest pass-through
					if ($urandom_range(9) < 8)
						e = 7'($urandom_range(rope_pkg::HALF - 1));
					else
						e = 7'($urandom_range(127, rope_pkg::HALF));
					send_pair(6'($urandom), 1'($urandom), e, rand_value(), rand_value());
					// hold off once until everything has come back
					if (ph == 3 && blk == 0 && n == 60)
						drain();
				end
			end
		end
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		in_valid       = 1'b0;
		head_index     = '0;
		key_not_query  = 1'b0;
		elem_index     = '0;
		first_value    = '0;
		second_value   = '0;
		out_ready      = 1'b1;
		errors         = 0;
		items_sent     = 0;
		results_seen   = 0;
		positions_set  = 0;
		cycles         = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		make_turn_rate();
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_identity();
		test_saturation();
		test_all_slots();
		test_random();
		drain();

		$display("covered %0d items, %0d results, %0d token positions, %0d cycles",
			items_sent, results_seen, positions_set, cycles);
		$display("phases: free flow, sender gaps, receiver stalls, both; %0d errors",
			errors);
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

/* files.f */
hdl/rope_pkg.sv
hdl/rope_ram.sv
hdl/rope_fill.sv
hdl/rope_rot.sv
hdl/rotary_position_embedding.sv
tb/testbench.sv
